[hw/rtl/cct_pkg.sv]
// Shared types and constants for the circle collision test pipeline.
`default_nettype none

package cct_pkg;

   typedef enum logic {
      MODE_CIRCLE = 1'b0,
      MODE_BOX    = 1'b1
   } mode_type;

   localparam int LEN_FRAC    = 16;
   localparam int NORMAL_W    = 16;
   localparam int DEPTH_W     = 22;
   localparam int OUT_DATA_W  = 1 + 4 * NORMAL_W + DEPTH_W;
   localparam int OUT_TDATA_W = ((OUT_DATA_W + 7) / 8) * 8;
   localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

endpackage

`default_nettype wire

[hw/rtl/circle_collision_test.sv]
// Circle-circle and circle-box collision test: one pair test per word, fully pipelined.
//
// Input channel req_*: one pair test per word; req_tuser selects the mode
// (0 circle against circle, 1 circle against axis-aligned box).
// Result channel rsp_*: one result word per input word, in order: hit flag,
// unit contact normal (Q1.NORMAL_FRAC_BITS), partner normal and depth.
// Throughput: one word per cycle while rsp_tready is high or the output register
// is empty. Stages: four setup stages (box edges, clamp, squares, distance
// compare), one stage per root bit of the COORD_BITS + 16 bit square root, a
// numerator stage plus one stage per quotient bit of the NORMAL_FRAC_BITS + 2
// bit normal divider, and the output register.
// Reset (synchronous, active high) empties every stage; no words are in
// flight afterwards. When rsp_tready is low with a word held in the output
// register, the whole pipeline freezes and req_tready drops; bubbles in
// the output register are filled regardless of rsp_tready, so no word is
// lost or repeated.
`default_nettype none

module circle_collision_test #(
   parameter int COORD_BITS       = 16,
   parameter int DEPTH_FRAC_BITS  = 4,
   parameter int NORMAL_FRAC_BITS = 14
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_tvalid,
   output logic                                       req_tready,
   // circle_x, circle_y, circle_radius, other_x, other_y, other_radius,
   // box_half_width, box_half_height
   input  wire logic [((8*COORD_BITS-4+7)/8)*8-1:0]   req_tdata,
   // mode
   input  wire logic [0:0]                            req_tuser,
   output logic                                       rsp_tvalid,
   input  wire logic                                  rsp_tready,
   // hit, normal_x, normal_y, partner_normal_x, partner_normal_y, depth
   output logic [cct_pkg::OUT_TDATA_W-1:0]            rsp_tdata
);

   localparam int C      = COORD_BITS;
   localparam int F      = DEPTH_FRAC_BITS;
   localparam int N      = NORMAL_FRAC_BITS;
   localparam int RAD_W  = C - 1;
   localparam int EW     = C + 1;
   localparam int DW     = C + 2;
   localparam int SQ_W   = 2 * DW;
   localparam int SUM_W  = SQ_W + 1;
   localparam int D2_W   = 2 * C;
   localparam int RW     = C + cct_pkg::LEN_FRAC;
   localparam int QB     = N + 2;
   localparam int QW     = QB + cct_pkg::NORMAL_W;
   localparam int DWID   = C + F + 1;
   localparam int DX_W   = DWID + cct_pkg::DEPTH_W;
   localparam int SQS_W  = 3 * C + 4;
   localparam int DVS_W  = 5 + cct_pkg::DEPTH_W;
   localparam int NW     = cct_pkg::NORMAL_W;
   localparam int OFF_CY = C;
   localparam int OFF_CR = 2 * C;
   localparam int OFF_OX = 3 * C - 1;
   localparam int OFF_OY = 4 * C - 1;
   localparam int OFF_OR = 5 * C - 1;
   localparam int OFF_HW = 6 * C - 2;
   localparam int OFF_HH = 7 * C - 3;
   localparam logic [QB-1:0] Q_ONE = QB'(1) << N;

   function automatic logic signed [DW-1:0] box_delta(input logic signed [C-1:0] c,
                                                     input logic signed [EW-1:0] lo,
                                                     input logic signed [EW-1:0] hi);
      logic signed [DW-1:0] ce;
      ce = DW'(c);
      if (ce < DW'(lo)) begin
         box_delta = ce - DW'(lo);
      end else if (ce > DW'(hi)) begin
         box_delta = ce - DW'(hi);
      end else begin
         box_delta = '0;
      end
   endfunction

   logic en;
   logic out_valid_ff;

   assign en         = !out_valid_ff || rsp_tready;
   assign req_tready = en;

   // stage A: unpack, box edges, radius sum (circle radius alone in box mode)
   logic signed [C-1:0]  in_cx, in_cy, in_ox, in_oy;
   logic [RAD_W-1:0]     in_cr, in_or, in_hw, in_hh;
   cct_pkg::mode_type    in_mode;

   assign in_cx   = req_tdata[0 +: C];
   assign in_cy   = req_tdata[OFF_CY +: C];
   assign in_cr   = req_tdata[OFF_CR +: RAD_W];
   assign in_ox   = req_tdata[OFF_OX +: C];
   assign in_oy   = req_tdata[OFF_OY +: C];
   assign in_or   = req_tdata[OFF_OR +: RAD_W];
   assign in_hw   = req_tdata[OFF_HW +: RAD_W];
   assign in_hh   = req_tdata[OFF_HH +: RAD_W];
   assign in_mode = cct_pkg::mode_type'(req_tuser[0]);

   logic                 valid_a_ff;
   cct_pkg::mode_type    mode_a_ff;
   logic signed [C-1:0]  cx_a_ff, cy_a_ff, ox_a_ff, oy_a_ff;
   logic signed [EW-1:0] lox_a_ff, hix_a_ff, loy_a_ff, hiy_a_ff;
   logic [C-1:0]         s_a_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
      end else if (en) begin
         valid_a_ff <= req_tvalid;
      end
      if (en) begin
         mode_a_ff <= in_mode;
         cx_a_ff   <= in_cx;
         cy_a_ff   <= in_cy;
         ox_a_ff   <= in_ox;
         oy_a_ff   <= in_oy;
         lox_a_ff  <= EW'(in_ox) - $signed(EW'(in_hw));
         hix_a_ff  <= EW'(in_ox) + $signed(EW'(in_hw));
         loy_a_ff  <= EW'(in_oy) - $signed(EW'(in_hh));
         hiy_a_ff  <= EW'(in_oy) + $signed(EW'(in_hh));
         if (in_mode == cct_pkg::MODE_BOX) begin
            s_a_ff <= C'(in_cr);
         end else begin
            s_a_ff <= C'(in_cr) + C'(in_or);
         end
      end
   end

   // stage B: direction vector
   logic                 valid_b_ff;
   cct_pkg::mode_type    mode_b_ff;
   logic signed [DW-1:0] dx_b_ff, dy_b_ff;
   logic [C-1:0]         s_b_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_b_ff <= 1'b0;
      end else if (en) begin
         valid_b_ff <= valid_a_ff;
      end
      if (en) begin
         mode_b_ff <= mode_a_ff;
         s_b_ff    <= s_a_ff;
         if (mode_a_ff == cct_pkg::MODE_BOX) begin
            dx_b_ff <= box_delta(cx_a_ff, lox_a_ff, hix_a_ff);
            dy_b_ff <= box_delta(cy_a_ff, loy_a_ff, hiy_a_ff);
         end else begin
            dx_b_ff <= DW'(cx_a_ff) - DW'(ox_a_ff);
            dy_b_ff <= DW'(cy_a_ff) - DW'(oy_a_ff);
         end
      end
   end

   // stage C: magnitudes and squares
   logic [DW-1:0]     ax_b, ay_b;
   logic              valid_c_ff;
   cct_pkg::mode_type mode_c_ff;
   logic [SQ_W-1:0]   sqx_c_ff, sqy_c_ff;
   logic [D2_W-1:0]   s2_c_ff;
   logic [C-1:0]      s_c_ff, mx_c_ff, my_c_ff;
   logic              sx_c_ff, sy_c_ff;

   assign ax_b = dx_b_ff[DW-1] ? DW'(-dx_b_ff) : DW'(dx_b_ff);
   assign ay_b = dy_b_ff[DW-1] ? DW'(-dy_b_ff) : DW'(dy_b_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_c_ff <= 1'b0;
      end else if (en) begin
         valid_c_ff <= valid_b_ff;
      end
      if (en) begin
         mode_c_ff <= mode_b_ff;
         sqx_c_ff  <= ax_b * ax_b;
         sqy_c_ff  <= ay_b * ay_b;
         s2_c_ff   <= s_b_ff * s_b_ff;
         s_c_ff    <= s_b_ff;
         mx_c_ff   <= ax_b[C-1:0];
         my_c_ff   <= ay_b[C-1:0];
         sx_c_ff   <= dx_b_ff[DW-1];
         sy_c_ff   <= dy_b_ff[DW-1];
      end
   end

   // stage D: squared distance and hit
   logic [SUM_W-1:0]  d2_c;
   logic              valid_d_ff;
   cct_pkg::mode_type mode_d_ff;
   logic              hit_d_ff;
   logic [D2_W-1:0]   d2_d_ff;
   logic [C-1:0]      s_d_ff, mx_d_ff, my_d_ff;
   logic              sx_d_ff, sy_d_ff;

   assign d2_c = SUM_W'(sqx_c_ff) + SUM_W'(sqy_c_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_d_ff <= 1'b0;
      end else if (en) begin
         valid_d_ff <= valid_c_ff;
      end
      if (en) begin
         mode_d_ff <= mode_c_ff;
         if (mode_c_ff == cct_pkg::MODE_BOX) begin
            hit_d_ff <= (d2_c < SUM_W'(s2_c_ff));
         end else begin
            hit_d_ff <= (d2_c <= SUM_W'(s2_c_ff));
         end
         d2_d_ff <= d2_c[D2_W-1:0];
         s_d_ff  <= s_c_ff;
         mx_d_ff <= mx_c_ff;
         my_d_ff <= my_c_ff;
         sx_d_ff <= sx_c_ff;
         sy_d_ff <= sy_c_ff;
      end
   end

   // distance root
   logic             sq_valid;
   logic [RW-1:0]    sq_len;
   logic             sq_exact;
   logic [SQS_W-1:0] sq_side;
   logic             sq_mode, sq_hit, sq_sx, sq_sy;
   logic [C-1:0]     sq_mx, sq_my, sq_s;

   cct_sqrt #(
      .IN_W   (D2_W),
      .FRAC   (cct_pkg::LEN_FRAC),
      .SIDE_W (SQS_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (valid_d_ff),
      .in_value  (d2_d_ff),
      .in_side   ({mode_d_ff, hit_d_ff, sx_d_ff, sy_d_ff, mx_d_ff, my_d_ff, s_d_ff}),
      .out_valid (sq_valid),
      .out_root  (sq_len),
      .out_exact (sq_exact),
      .out_side  (sq_side)
   );

   assign {sq_mode, sq_hit, sq_sx, sq_sy, sq_mx, sq_my, sq_s} = sq_side;

   // depth from the root
   logic                        exact_all;
   logic [DWID-1:0]             full, dist_val, depth_raw;
   logic [DX_W-1:0]             depth_ext;
   logic [cct_pkg::DEPTH_W-1:0] depth_sat;
   logic                        len_zero;

   always_comb begin
      exact_all = sq_exact && (sq_len[cct_pkg::LEN_FRAC-F-1:0] == '0);
      full      = DWID'(sq_s) << F;
      dist_val  = DWID'(sq_len >> (cct_pkg::LEN_FRAC - F)) + DWID'(!exact_all);
      depth_raw = (full > dist_val) ? (full - dist_val) : '0;
      depth_ext = DX_W'(depth_raw);
      if (depth_ext > DX_W'(cct_pkg::DEPTH_MAX)) begin
         depth_sat = cct_pkg::DEPTH_MAX;
      end else begin
         depth_sat = depth_ext[cct_pkg::DEPTH_W-1:0];
      end
      len_zero = (sq_len == '0);
   end

   // normal division
   logic                        dv_valid;
   logic [QB-1:0]               dv_qx, dv_qy;
   logic [DVS_W-1:0]            dv_side;
   logic                        dv_mode, dv_hit, dv_sx, dv_sy, dv_lz;
   logic [cct_pkg::DEPTH_W-1:0] dv_depth;

   cct_div #(
      .MAG_W  (C),
      .LEN_W  (RW),
      .QB     (QB),
      .SHIFT  (N + cct_pkg::LEN_FRAC),
      .SIDE_W (DVS_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (sq_valid),
      .in_mag_x  (sq_mx),
      .in_mag_y  (sq_my),
      .in_len    (sq_len),
      .in_side   ({sq_mode, sq_hit, sq_sx, sq_sy, len_zero, depth_sat}),
      .out_valid (dv_valid),
      .out_quo_x (dv_qx),
      .out_quo_y (dv_qy),
      .out_side  (dv_side)
   );

   assign {dv_mode, dv_hit, dv_sx, dv_sy, dv_lz, dv_depth} = dv_side;

   // clamp, sign and output register
   logic [QB-1:0] qcx, qcy;
   logic [QW-1:0] wx, wy, nwx, nwy;
   logic [NW-1:0] nx, ny, pnx, pny;

   always_comb begin
      qcx = (dv_qx > Q_ONE) ? Q_ONE : dv_qx;
      qcy = (dv_qy > Q_ONE) ? Q_ONE : dv_qy;
      wx  = QW'(qcx);
      wy  = QW'(qcy);
      nwx = -wx;
      nwy = -wy;
      if (!dv_hit || dv_lz) begin
         nx = '0;
         ny = '0;
      end else begin
         nx = dv_sx ? nwx[NW-1:0] : wx[NW-1:0];
         ny = dv_sy ? nwy[NW-1:0] : wy[NW-1:0];
      end
      if (dv_mode == cct_pkg::MODE_BOX) begin
         pnx = -nx;
         pny = -ny;
      end else begin
         pnx = nx;
         pny = ny;
      end
   end

   logic                        hit_ff;
   cct_pkg::mode_type           mode_ff;
   logic [NW-1:0]               nx_ff, ny_ff, pnx_ff, pny_ff;
   logic [cct_pkg::DEPTH_W-1:0] depth_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= dv_valid;
      end
      if (en) begin
         hit_ff   <= dv_hit;
         mode_ff  <= cct_pkg::mode_type'(dv_mode);
         nx_ff    <= nx;
         ny_ff    <= ny;
         pnx_ff   <= pnx;
         pny_ff   <= pny;
         depth_ff <= dv_hit ? dv_depth : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = cct_pkg::OUT_TDATA_W'({depth_ff, pny_ff, pnx_ff, ny_ff, nx_ff, hit_ff});

   a_miss_clear : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !hit_ff |-> nx_ff == '0 && ny_ff == '0 && pnx_ff == '0
                                  && pny_ff == '0 && depth_ff == '0)
      else $error("miss word carries non-zero normal or depth");

   a_circle_partner : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && mode_ff == cct_pkg::MODE_CIRCLE |-> pnx_ff == nx_ff && pny_ff == ny_ff)
      else $error("circle partner normal differs from normal");

   a_box_partner : assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && mode_ff == cct_pkg::MODE_BOX
      |-> pnx_ff == NW'(-nx_ff) && pny_ff == NW'(-ny_ff))
      else $error("box partner normal is not the negated normal");

endmodule

`default_nettype wire

[hw/rtl/cct_sqrt.sv]
// Pipelined digit-by-digit square root, one result bit per stage, with sideband.
`default_nettype none

module cct_sqrt #(
   parameter int IN_W   = 32,
   parameter int FRAC   = cct_pkg::LEN_FRAC,
   parameter int SIDE_W = 1
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     en,
   input  wire logic                     in_valid,
   input  wire logic [IN_W-1:0]          in_value,
   input  wire logic [SIDE_W-1:0]        in_side,
   output logic                          out_valid,
   output logic [IN_W/2+FRAC-1:0]        out_root,
   output logic                          out_exact,
   output logic [SIDE_W-1:0]             out_side
);

   localparam int RW    = IN_W / 2 + FRAC;
   localparam int REM_W = RW + 3;

   logic [REM_W-1:0]  rem_ff   [RW];
   logic [RW-1:0]     root_ff  [RW];
   logic [IN_W-1:0]   rad_ff   [RW];
   logic [SIDE_W-1:0] side_ff  [RW];
   logic              valid_ff [RW];

   genvar k;
   for (k = 0; k < RW; k++) begin : g_step
      logic [REM_W-1:0]  rem_src;
      logic [RW-1:0]     root_src;
      logic [IN_W-1:0]   rad_src;
      logic [SIDE_W-1:0] side_src;
      logic              valid_src;
      logic [REM_W-1:0]  rem_cat;
      logic [REM_W-1:0]  trial;
      logic [REM_W-1:0]  rem_in;
      logic [RW-1:0]     root_in;
      logic [IN_W-1:0]   rad_in;

      if (k == 0) begin : g_first
         assign rem_src   = '0;
         assign root_src  = '0;
         assign rad_src   = in_value;
         assign side_src  = in_side;
         assign valid_src = in_valid;
      end else begin : g_next
         assign rem_src   = rem_ff[k-1];
         assign root_src  = root_ff[k-1];
         assign rad_src   = rad_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      always_comb begin
         rem_cat = {rem_src[REM_W-3:0], rad_src[IN_W-1 -: 2]};
         trial   = {1'b0, root_src, 2'b01};
         rad_in  = {rad_src[IN_W-3:0], 2'b00};
         if (rem_cat >= trial) begin
            rem_in  = rem_cat - trial;
            root_in = {root_src[RW-2:0], 1'b1};
         end else begin
            rem_in  = rem_cat;
            root_in = {root_src[RW-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[RW-1];
   assign out_root  = root_ff[RW-1];
   assign out_exact = (rem_ff[RW-1] == '0);
   assign out_side  = side_ff[RW-1];

endmodule

`default_nettype wire

[hw/rtl/cct_div.sv]
// Two-lane pipelined restoring divider, rounded numerator, one quotient bit per stage.
`default_nettype none

module cct_div #(
   parameter int MAG_W  = 16,
   parameter int LEN_W  = 32,
   parameter int QB     = 16,
   parameter int SHIFT  = 30,
   parameter int SIDE_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [MAG_W-1:0]  in_mag_x,
   input  wire logic [MAG_W-1:0]  in_mag_y,
   input  wire logic [LEN_W-1:0]  in_len,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [QB-1:0]          out_quo_x,
   output logic [QB-1:0]          out_quo_y,
   output logic [SIDE_W-1:0]      out_side
);

   localparam int NUM_W = MAG_W + SHIFT + 1;
   localparam int EXT_W = NUM_W + LEN_W;

   function automatic logic [LEN_W:0] div_step(input logic [LEN_W-1:0] rem,
                                               input logic nbit,
                                               input logic [LEN_W-1:0] len);
      logic [LEN_W:0] cat;
      logic [LEN_W:0] dif;
      cat = {rem, nbit};
      dif = cat - {1'b0, len};
      if (cat >= {1'b0, len}) begin
         div_step = {1'b1, dif[LEN_W-1:0]};
      end else begin
         div_step = {1'b0, cat[LEN_W-1:0]};
      end
   endfunction

   // numerator stage
   logic [NUM_W-1:0]  numx_ff;
   logic [NUM_W-1:0]  numy_ff;
   logic [LEN_W-1:0]  len0_ff;
   logic [SIDE_W-1:0] side0_ff;
   logic              valid0_ff;
   logic [EXT_W-1:0]  numx_ext;
   logic [EXT_W-1:0]  numy_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid0_ff <= 1'b0;
      end else if (en) begin
         valid0_ff <= in_valid;
      end
      if (en) begin
         numx_ff  <= NUM_W'({in_mag_x, {SHIFT{1'b0}}}) + NUM_W'(in_len >> 1);
         numy_ff  <= NUM_W'({in_mag_y, {SHIFT{1'b0}}}) + NUM_W'(in_len >> 1);
         len0_ff  <= in_len;
         side0_ff <= in_side;
      end
   end

   assign numx_ext = EXT_W'(numx_ff);
   assign numy_ext = EXT_W'(numy_ff);

   logic [LEN_W-1:0]  remx_ff  [QB];
   logic [LEN_W-1:0]  remy_ff  [QB];
   logic [QB-1:0]     lowx_ff  [QB];
   logic [QB-1:0]     lowy_ff  [QB];
   logic [QB-1:0]     qx_ff    [QB];
   logic [QB-1:0]     qy_ff    [QB];
   logic [LEN_W-1:0]  len_ff   [QB];
   logic [SIDE_W-1:0] side_ff  [QB];
   logic              valid_ff [QB];

   genvar k;
   for (k = 0; k < QB; k++) begin : g_step
      logic [LEN_W-1:0]  remx_src;
      logic [LEN_W-1:0]  remy_src;
      logic [QB-1:0]     lowx_src;
      logic [QB-1:0]     lowy_src;
      logic [QB-1:0]     qx_src;
      logic [QB-1:0]     qy_src;
      logic [LEN_W-1:0]  len_src;
      logic [SIDE_W-1:0] side_src;
      logic              valid_src;
      logic [LEN_W:0]    stepx;
      logic [LEN_W:0]    stepy;

      if (k == 0) begin : g_first
         assign remx_src  = numx_ext[QB +: LEN_W];
         assign remy_src  = numy_ext[QB +: LEN_W];
         assign lowx_src  = numx_ff[QB-1:0];
         assign lowy_src  = numy_ff[QB-1:0];
         assign qx_src    = '0;
         assign qy_src    = '0;
         assign len_src   = len0_ff;
         assign side_src  = side0_ff;
         assign valid_src = valid0_ff;
      end else begin : g_next
         assign remx_src  = remx_ff[k-1];
         assign remy_src  = remy_ff[k-1];
         assign lowx_src  = lowx_ff[k-1];
         assign lowy_src  = lowy_ff[k-1];
         assign qx_src    = qx_ff[k-1];
         assign qy_src    = qy_ff[k-1];
         assign len_src   = len_ff[k-1];
         assign side_src  = side_ff[k-1];
         assign valid_src = valid_ff[k-1];
      end

      assign stepx = div_step(remx_src, lowx_src[QB-1], len_src);
      assign stepy = div_step(remy_src, lowy_src[QB-1], len_src);

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_src;
         end
         if (en) begin
            remx_ff[k] <= stepx[LEN_W-1:0];
            remy_ff[k] <= stepy[LEN_W-1:0];
            lowx_ff[k] <= lowx_src << 1;
            lowy_ff[k] <= lowy_src << 1;
            qx_ff[k]   <= {qx_src[QB-2:0], stepx[LEN_W]};
            qy_ff[k]   <= {qy_src[QB-2:0], stepy[LEN_W]};
            len_ff[k]  <= len_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = valid_ff[QB-1];
   assign out_quo_x = qx_ff[QB-1];
   assign out_quo_y = qy_ff[QB-1];
   assign out_side  = side_ff[QB-1];

endmodule

`default_nettype wire

[dv/circle_collision_test_tb.sv]
// Testbench for circle_collision_test: streams pair tests and checks each result word.
`timescale 1ns / 100ps
`default_nettype none

module circle_collision_test_tb;

   localparam int IN_W  = ((8*16-4+7)/8)*8;
   localparam int LIMIT = 400000;

   typedef struct packed {
      cct_pkg::mode_type mode;
      logic [15:0]       cx, cy;
      logic [14:0]       cr;
      logic [15:0]       ox, oy;
      logic [14:0]       orad, hw, hh;
   } pair_type;

   typedef struct packed {
      logic [21:0] depth;
      logic [15:0] py, px, ny, nx;
      logic        hit;
   } contact_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [IN_W-1:0] req_tdata = '0;
   logic [0:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [cct_pkg::OUT_TDATA_W-1:0] rsp_tdata;

   contact_type expected_contacts[$];
   int errors = 0;
   int send_idle = 0;
   int recv_stall = 0;
   longint cycles = 0;

   always #5 clock = ~clock;

   circle_collision_test dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // floor(sqrt(v * 4^f))
   function automatic longint unsigned isqrt_scaled(longint unsigned v, int f,
                                                    output bit exact);
      longint unsigned root, rem, trial, pair;
      root = 0;
      rem = 0;
      for (int i = 31 + f; i >= 0; i--) begin
         pair = (i >= f) ? ((v >> (2*(i-f))) & 3) : 0;
         rem = (rem << 2) | pair;
         trial = (root << 2) | 1;
         if (rem >= trial) begin
            rem -= trial;
            root = (root << 1) | 1;
         end else begin
            root = root << 1;
         end
      end
      exact = (rem == 0);
      return root;
   endfunction

   function automatic logic [15:0] unit_component(longint c, longint unsigned len);
      longint unsigned mag, q;
      if (len == 0) return '0;
      mag = (c < 0) ? -c : c;
      q = ((mag << 30) + (len >> 1)) / len;
      if (q > (1 << 14)) q = 1 << 14;
      if (c < 0) q = -q;
      return q[15:0];
   endfunction

   function automatic contact_type predict_contact(pair_type p);
      contact_type r;
      longint cx, cy, ox, oy, hw, hh, tx, ty, dx, dy;
      longint unsigned s, d2, len, dist_val, full, dep;
      bit exact;
      r = '0;
      cx = $signed(p.cx); cy = $signed(p.cy);
      ox = $signed(p.ox); oy = $signed(p.oy);
      hw = p.hw; hh = p.hh;
      if (p.mode == cct_pkg::MODE_BOX) begin
         tx = cx; ty = cy;
         if (cx < ox - hw) tx = ox - hw;
         else if (cx > ox + hw) tx = ox + hw;
         if (cy < oy - hh) ty = oy - hh;
         else if (cy > oy + hh) ty = oy + hh;
         dx = cx - tx; dy = cy - ty;
         s = p.cr;
      end else begin
         dx = cx - ox; dy = cy - oy;
         s = p.cr + p.orad;
      end
      d2 = dx*dx + dy*dy;
      if (p.mode == cct_pkg::MODE_BOX ? !(d2 < s*s) : !(d2 <= s*s)) return r;
      len = isqrt_scaled(d2, cct_pkg::LEN_FRAC, exact);
      r.hit = 1'b1;
      r.nx = unit_component(dx, len);
      r.ny = unit_component(dy, len);
      dist_val = isqrt_scaled(d2, 4, exact);
      if (!exact) dist_val++;
      full = s << 4;
      dep = (full > dist_val) ? full - dist_val : 0;
      if (dep > cct_pkg::DEPTH_MAX) dep = cct_pkg::DEPTH_MAX;
      r.depth = dep[21:0];
      r.px = (p.mode == cct_pkg::MODE_BOX) ? -r.nx : r.nx;
      r.py = (p.mode == cct_pkg::MODE_BOX) ? -r.ny : r.ny;
      return r;
   endfunction

   task automatic send_pair(pair_type p);
      while (send_idle > 0 && $urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {p.hh, p.hw, p.orad, p.oy, p.ox, p.cr, p.cy, p.cx};
      req_tuser <= p.mode;
      expected_contacts.push_back(predict_contact(p));
      do @(posedge clock); while (!req_tready);
   endtask

   // receiver stall pattern
   always @(posedge clock)
      rsp_tready <= (recv_stall == 0) ? 1'b1 : ($urandom_range(99) >= recv_stall);

   always @(posedge clock) begin
      contact_type e, a;
      if (!reset && rsp_tvalid && rsp_tready) begin
         a = rsp_tdata[cct_pkg::OUT_DATA_W-1:0];
         if (expected_contacts.size() == 0) begin
            $display("%0t unexpected word %h", $time, rsp_tdata);
            errors++;
         end else begin
            e = expected_contacts.pop_front();
            if (a != e) begin
               $display("%0t mismatch exp hit=%b n=%h,%h p=%h,%h d=%h", $time,
                        e.hit, e.nx, e.ny, e.px, e.py, e.depth);
               $display("%0t          got hit=%b n=%h,%h p=%h,%h d=%h", $time,
                        a.hit, a.nx, a.ny, a.px, a.py, a.depth);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("[circle_collision_test] ERROR");
         $finish;
      end
   end

   function automatic pair_type random_pair();
      pair_type p;
      int span;
      p.mode = cct_pkg::mode_type'($urandom_range(1));
      p.cx = 16'($urandom); p.cy = 16'($urandom);
      p.cr = 15'($urandom); p.orad = 15'($urandom);
      p.hw = 15'($urandom); p.hh = 15'($urandom);
      if ($urandom_range(3) != 0) begin
         // near miss or contact region
         span = 1 << $urandom_range(14, 2);
         p.cr = 15'($urandom_range(span));
         p.orad = 15'($urandom_range(span));
         p.hw = 15'($urandom_range(span));
         p.hh = 15'($urandom_range(span));
         p.ox = 16'($signed(p.cx) + $signed(16'($urandom_range(4*span))) - 2*span);
         p.oy = 16'($signed(p.cy) + $signed(16'($urandom_range(4*span))) - 2*span);
      end else begin
         p.ox = 16'($urandom); p.oy = 16'($urandom);
      end
      return p;
   endfunction

   task automatic test_directed();
      pair_type p;
      p = '{cct_pkg::MODE_CIRCLE, 16'sd0, 16'sd0, 15'd10, 16'sd0, 16'sd0, 15'd5, 15'd0,
            15'd0};
      send_pair(p);                              // coincident centres
      p.cx = 16'sd15; send_pair(p);              // touching exactly
      p.cx = 16'sd16; send_pair(p);              // just apart
      p.cx = 16'sd9; p.cy = -16'sd7; send_pair(p);
      p = '{cct_pkg::MODE_CIRCLE, 16'h8000, 16'h8000, 15'h7FFF, 16'h7FFF, 16'h7FFF,
            15'h7FFF, 15'h7FFF, 15'h7FFF};
      send_pair(p);
      p.cx = 16'h7FFF; p.cy = 16'h7FFF; send_pair(p);
      p.cx = 16'h8000; p.ox = 16'h7FFF; p.oy = 16'h8000; send_pair(p);
      p = '{cct_pkg::MODE_BOX, 16'sd3, 16'sd2, 15'd4, 16'sd0, 16'sd0, 15'd0, 15'd5, 15'd5};
      send_pair(p);                              // centre inside box
      p.cx = 16'sd9; send_pair(p);               // distance equals radius
      p.cx = 16'sd8; send_pair(p);
      p.cx = 16'sd8; p.cy = 16'sd8; send_pair(p); // corner
      p.cx = -16'sd8; p.cy = -16'sd7; send_pair(p);
      p = '{cct_pkg::MODE_BOX, 16'h8000, 16'h8000, 15'h7FFF, 16'h7FFF, 16'h7FFF,
            15'h7FFF, 15'h7FFF, 15'h7FFF};
      send_pair(p);
      p.hw = 15'd0; p.hh = 15'd0; send_pair(p);
      p.cr = 15'd0; p.cx = 16'h7FFF; p.cy = 16'h7FFF; send_pair(p);
      p = '{cct_pkg::MODE_BOX, 16'sd0, 16'sd0, 15'd0, 16'sd0, 16'sd0, 15'h7FFF, 15'd0,
            15'd0};
      send_pair(p);                              // zero radius never hits a box
   endtask

   task automatic test_random(int count, int idle, int stall);
      send_idle = idle;
      recv_stall = stall;
      repeat (count) send_pair(random_pair());
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random(300, 0, 0);
      test_random(250, 45, 0);
      test_random(250, 0, 45);
      test_random(250, 22, 22);
      req_tvalid <= 1'b0;
      recv_stall = 0;
      while (expected_contacts.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
      if (errors == 0)
         $display("[circle_collision_test] OK");
      else
         $display("[circle_collision_test] ERROR");
      $finish;
   end
endmodule

`default_nettype wire

[circle_collision_test.f]
hw/rtl/cct_pkg.sv
hw/rtl/cct_sqrt.sv
hw/rtl/cct_div.sv
hw/rtl/circle_collision_test.sv
dv/circle_collision_test_tb.sv
